### design/fcfla_pkg.sv
// Package for the fixed-chunk free-list allocator.
// Holds pool sizing constants, request and status codes and the sequencer state type.
// No dependencies.
package fcfla_pkg;

	// Pool sizing
	localparam int CHUNKS  = 256;
	localparam int IDX_W   = $clog2(CHUNKS);
	localparam int LINK_W  = IDX_W + 1;
	localparam int COUNT_W = 9;
	localparam int BYTES_W = 13;
	localparam int OFF_W   = 20;
	localparam int PROD_W  = IDX_W + BYTES_W;

	// Configuration register indexes
	localparam logic CFG_CHUNK_COUNT = 1'b0;
	localparam logic CFG_CHUNK_BYTES = 1'b1;

	// Request opcodes
	typedef enum logic [1:0] {
		OP_ALLOC    = 2'd0,
		OP_FREE     = 2'd1,
		OP_FREE_ALL = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK
	} state_t;

endpackage

### design/fixed_chunk_free_list_allocator.sv
// An allocate or free has an accept cycle, in which the link store is read at
// the current list head, and an execute cycle, in which the registered link word is used and
// the store is written back; the request after it can be accepted in the cycle that follows.
// A finished result waits in the output register without holding up the next request, but
// the execute cycle stalls while that register is still full. Free-all loads its result in
// its execute cycle and then rewrites the link store one entry per cycle over the live chunk
// count with the input held off until the walk ends. After reset the same walk links all
// 256 entries, and the input stays held off until it is done.
//
// Top level of the fixed-chunk free-list allocator: link store, head register, output register.
// Depends on fcfla_pkg.
module fixed_chunk_free_list_allocator import fcfla_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [BYTES_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [IDX_W-1:0]   free_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [IDX_W-1:0]   chunk_index,
	output logic [OFF_W-1:0]   byte_offset
);

	// Configuration and list state
	logic [COUNT_W-1:0] chunk_count_q;
	logic [BYTES_W-1:0] chunk_bytes_q;
	logic [LINK_W-1:0]  head_q;

	// Relink walk position and end
	logic [LINK_W-1:0]  walk_q;
	logic [LINK_W-1:0]  walk_end_q;

	// Link store and its registered read port
	logic [LINK_W-1:0]  link_mem [CHUNKS];
	logic [LINK_W-1:0]  rd_data_q;

	// Request stage
	state_t             state_q, state_d;
	logic [1:0]         op_s1;
	logic [IDX_W-1:0]   idx_s1;

	// Output register
	logic               out_valid_q;
	status_t            status_q;
	logic [IDX_W-1:0]   chunk_index_q;
	logic [OFF_W-1:0]   byte_offset_q;

	// Execute-cycle control
	logic               accept;
	logic               exec_go;
	logic [COUNT_W-1:0] live_count;
	logic [PROD_W-1:0]  product;
	logic               do_pop;
	logic               do_push;
	logic               do_relink;
	logic               walk_wr;
	status_t            status_d;

	// Saturate the count to the pool size; this value is also the null link
	assign live_count = (chunk_count_q > COUNT_W'(CHUNKS)) ? COUNT_W'(CHUNKS) : chunk_count_q;

	assign product = PROD_W'(head_q[IDX_W-1:0]) * PROD_W'(chunk_bytes_q);

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	// Sequencer next state and execute decode
	always_comb begin
		state_d   = state_q;
		exec_go   = 1'b0;
		do_pop    = 1'b0;
		do_push   = 1'b0;
		do_relink = 1'b0;
		walk_wr   = 1'b0;
		status_d  = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				exec_go = !out_valid_q || out_ready;
				if (exec_go) begin
					state_d = S_IDLE;
				end
				case (op_t'(op_s1))
					OP_ALLOC: begin
						if (COUNT_W'(head_q) >= live_count) begin
							status_d = ST_EMPTY;
						end else begin
							do_pop = exec_go;
						end
					end
					OP_FREE: begin
						if (COUNT_W'(idx_s1) >= live_count) begin
							status_d = ST_RANGE;
						end else begin
							do_push = exec_go;
						end
					end
					OP_FREE_ALL: begin
						do_relink = exec_go;
						if (exec_go && live_count != '0) begin
							state_d = S_WALK;
						end
					end
					default: begin
						status_d = ST_OK;
					end
				endcase
			end
			S_WALK: begin
				// Link one entry to its successor per cycle until the end is reached
				walk_wr = 1'b1;
				if (walk_q + LINK_W'(1) == walk_end_q) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state, configuration, head and walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_WALK;
			chunk_count_q <= COUNT_W'(256);
			chunk_bytes_q <= BYTES_W'(16);
			head_q        <= '0;
			walk_q        <= '0;
			walk_end_q    <= LINK_W'(CHUNKS);
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_CHUNK_COUNT) begin
					chunk_count_q <= cfg_data[COUNT_W-1:0];
				end else begin
					chunk_bytes_q <= cfg_data;
				end
			end
			if (do_pop) begin
				head_q <= rd_data_q;
			end else if (do_push) begin
				head_q <= LINK_W'(idx_s1);
			end else if (do_relink) begin
				head_q <= '0;
			end
			// Latch the walk end so a later count change does not cut it short
			if (do_relink) begin
				walk_q     <= '0;
				walk_end_q <= LINK_W'(live_count);
			end else if (walk_wr) begin
				walk_q <= walk_q + LINK_W'(1);
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Link store: write on push or walk, read at the head every cycle
	always_ff @(posedge clk) begin
		if (do_push) begin
			link_mem[idx_s1] <= head_q;
		end else if (walk_wr) begin
			link_mem[walk_q[IDX_W-1:0]] <= walk_q + LINK_W'(1);
		end
		rd_data_q <= link_mem[head_q[IDX_W-1:0]];
	end

	// Capture the request and load the result
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode;
			idx_s1 <= free_index;
		end
		if (exec_go) begin
			status_q <= status_d;
			if (do_pop) begin
				chunk_index_q <= head_q[IDX_W-1:0];
				byte_offset_q <= product[OFF_W-1:0];
			end else begin
				chunk_index_q <= '0;
				byte_offset_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign chunk_index = chunk_index_q;
	assign byte_offset = byte_offset_q;

endmodule

### design/fcfla_checker.sv
// Port-level checker for the fixed-chunk free-list allocator, bound to the top level.
// Depends on fcfla_pkg and fixed_chunk_free_list_allocator.
module fcfla_checker import fcfla_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [IDX_W-1:0]   chunk_index,
	input logic [OFF_W-1:0]   byte_offset
);

	// Hold a stalled result steady
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(chunk_index)
			&& $stable(byte_offset))
		else $error("result changed while stalled");

	// Report only defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_RANGE))
		else $error("undefined status code");

	// Zero the index and offset on any failed request
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> chunk_index == '0 && byte_offset == '0)
		else $error("failed request carries nonzero fields");

	// Never take requests back to back
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted in back-to-back cycles");

endmodule

bind fixed_chunk_free_list_allocator fcfla_checker u_fcfla_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.chunk_index (chunk_index),
	.byte_offset (byte_offset)
);
